// File: hw/rtl/bounded_deque_with_index_read_top_defines.svh
// Assertion macros for the bounded deque block
`ifndef BOUNDED_DEQUE_WITH_INDEX_READ_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INDEX_READ_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bdq_pkg.sv
// Package: types, codes and sizes shared by the bounded deque modules
package bdq_pkg;

   // default sizes of the entry row
   localparam int DEPTH_DEF     = 256;
   localparam int ELEM_BITS_DEF = 24;

   // fixed widths of the transfer fields
   localparam int OP_W    = 3;
   localparam int VALUE_W = 24;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;
   localparam int STAT_W  = 2;

   // operation codes; codes above OP_READ do nothing
   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_REM_HEAD = 3'd2,
      OP_REM_TAIL = 3'd3,
      OP_READ     = 3'd4
   } op_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEEK,
      FSM_RETURN
   } fsm_type;

   // per-cell move of the row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROT_L,
      CELL_ROT_R,
      CELL_WRITE
   } cell_op_type;

   // command broadcast to the row; head_load feeds new data into cell 0 on ROT_R
   typedef struct packed {
      cell_op_type op;
      logic        head_load;
   } row_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [VALUE_W-1:0] head_value;
      logic [VALUE_W-1:0] tail_value;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } rsp_type;

endpackage

// File: hw/rtl/bdq_cell.sv
// One storage cell of the entry row
module bdq_cell #(
   parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
   parameter int ELEM_BITS = bdq_pkg::ELEM_BITS_DEF,
   parameter int POS       = 0
) (
   input  logic                         clock,
   input  bdq_pkg::cell_op_type         cell_op,
   input  logic [ELEM_BITS-1:0]         left_data,
   input  logic [ELEM_BITS-1:0]         right_data,
   input  logic [$clog2(DEPTH)-1:0]     wr_pos,
   input  logic [ELEM_BITS-1:0]         wr_data,
   output logic [ELEM_BITS-1:0]         data_out
);
   import bdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [ELEM_BITS-1:0] data_ff;
   logic [ELEM_BITS-1:0] data_in;

   // pick the next word: hold, take a neighbor, or take a write aimed here
   always_comb begin
      data_in = data_ff;
      case (cell_op)
         CELL_HOLD:  data_in = data_ff;
         CELL_ROT_L: data_in = right_data;
         CELL_ROT_R: data_in = left_data;
         CELL_WRITE: begin
            if (wr_pos == IDX_W'(POS)) begin
               data_in = wr_data;
            end
         end
         default:    data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// File: hw/rtl/bdq_row.sv
// Ring of storage cells; cell 0 always holds the word at the rotation point
module bdq_row #(
   parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
   parameter int ELEM_BITS = bdq_pkg::ELEM_BITS_DEF
) (
   input  logic                         clock,
   input  bdq_pkg::row_cmd_type         cmd,
   input  logic [$clog2(DEPTH)-1:0]     wr_pos,
   input  logic [ELEM_BITS-1:0]         wr_data,
   output logic [ELEM_BITS-1:0]         head_data
);
   import bdq_pkg::*;

   logic [ELEM_BITS-1:0] cell_data [DEPTH];
   logic [ELEM_BITS-1:0] left_into_first;

   // close the ring, or feed a new head word into cell 0
   assign left_into_first = cmd.head_load ? wr_data : cell_data[DEPTH-1];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_BITS-1:0] left_w;
      if (i == 0) begin : g_first
         assign left_w = left_into_first;
      end else begin : g_rest
         assign left_w = cell_data[i-1];
      end

      bdq_cell #(
         .DEPTH     (DEPTH),
         .ELEM_BITS (ELEM_BITS),
         .POS       (i)
      ) u_cell (
         .clock      (clock),
         .cell_op    (cmd.op),
         .left_data  (left_w),
         .right_data (cell_data[(i + 1) % DEPTH]),
         .wr_pos     (wr_pos),
         .wr_data    (wr_data),
         .data_out   (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

// File: hw/rtl/bounded_deque_with_index_read_top.sv
// Top level of the bounded deque with indexed read
//
// Usage: drive req_data and raise start; the request is transferred at a clock
// edge where start is high and busy is low. Every request gives exactly one
// result on rsp_data, shown for one cycle with rsp_strobe high; the receiver
// cannot stall, so it must take the result in that cycle.
// Entries live in a ring of DEPTH cells with the head always in cell 0; the
// ring shifts one place per cycle as a whole.
// Inserts, head removal, reads of index 0, tail removal that leaves fewer
// than two entries, and every rejected request give the result in the cycle
// after the transfer, and a new request may be sent in that cycle.
// A read of index k > 0 rotates the ring k places and back before the result
// is shown. A tail removal leaving n >= 2 entries fetches the new tail the
// same way with k = n - 1.
// busy is high while a read or a tail fetch rotates the ring; head inserts
// and head removals rotate it with busy low.
// Reset clears the count, the controller and the strobe; stored words are
// left as they are and are never read before written.
module bounded_deque_with_index_read_top #(
   parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
   parameter int ELEM_BITS = bdq_pkg::ELEM_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   `include "bounded_deque_with_index_read_top_defines.svh"

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   fsm_type              state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ELEM_BITS-1:0] tail_ff, tail_in;
   logic [ELEM_BITS-1:0] rd_ff, rd_in;
   status_type           status_ff, status_in;
   logic [IDX_W-1:0]     remain_ff, remain_in;
   logic [IDX_W-1:0]     back_ff, back_in;
   logic                 to_read_ff, to_read_in;
   logic                 strobe_ff, strobe_in;

   row_cmd_type          cmd;
   logic [IDX_W-1:0]     wr_pos;
   logic [ELEM_BITS-1:0] wr_data;
   logic [ELEM_BITS-1:0] head_data;
   logic                 is_full;
   logic                 is_empty;

   assign wr_data  = ELEM_BITS'(req_data.value);
   assign wr_pos   = IDX_W'(count_ff);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   bdq_row #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS)
   ) u_row (
      .clock     (clock),
      .cmd       (cmd),
      .wr_pos    (wr_pos),
      .wr_data   (wr_data),
      .head_data (head_data)
   );

   // controller: decode the request, step the rotation, raise the result
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      tail_in    = tail_ff;
      rd_in      = rd_ff;
      status_in  = status_ff;
      remain_in  = remain_ff;
      back_in    = back_ff;
      to_read_in = to_read_ff;
      strobe_in  = 1'b0;
      cmd.op        = CELL_HOLD;
      cmd.head_load = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               status_in = ST_OK;
               rd_in     = '0;
               strobe_in = 1'b1;
               case (req_data.op)
                  OP_INS_HEAD: begin
                     if (!is_full) begin
                        cmd.op        = CELL_ROT_R;
                        cmd.head_load = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        if (is_empty) begin
                           tail_in = wr_data;
                        end
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_INS_TAIL: begin
                     if (!is_full) begin
                        cmd.op   = CELL_WRITE;
                        count_in = count_ff + CNT_W'(1);
                        tail_in  = wr_data;
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_REM_HEAD: begin
                     if (!is_empty) begin
                        cmd.op   = CELL_ROT_L;
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        status_in = ST_EMPTY;
                     end
                  end
                  OP_REM_TAIL: begin
                     if (!is_empty) begin
                        count_in = count_ff - CNT_W'(1);
                        if (count_ff == CNT_W'(2)) begin
                           tail_in = head_data;
                        end else if (count_ff > CNT_W'(2)) begin
                           // fetch the word one place before the old tail
                           back_in    = IDX_W'(count_ff - CNT_W'(2));
                           remain_in  = IDX_W'(count_ff - CNT_W'(2));
                           to_read_in = 1'b0;
                           strobe_in  = 1'b0;
                           state_in   = FSM_SEEK;
                        end
                     end else begin
                        status_in = ST_EMPTY;
                     end
                  end
                  OP_READ: begin
                     if (CMP_W'(req_data.index) < CMP_W'(count_ff)) begin
                        if (req_data.index == '0) begin
                           rd_in = head_data;
                        end else begin
                           back_in    = IDX_W'(req_data.index);
                           remain_in  = IDX_W'(req_data.index);
                           to_read_in = 1'b1;
                           strobe_in  = 1'b0;
                           state_in   = FSM_SEEK;
                        end
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_SEEK: begin
            if (remain_ff != '0) begin
               // advance the target toward cell 0
               cmd.op    = CELL_ROT_L;
               remain_in = remain_ff - IDX_W'(1);
            end else begin
               // capture the target and start turning the ring back
               if (to_read_ff) begin
                  rd_in = head_data;
               end else begin
                  tail_in = head_data;
               end
               cmd.op    = CELL_ROT_R;
               remain_in = back_ff - IDX_W'(1);
               if (back_ff == IDX_W'(1)) begin
                  strobe_in = 1'b1;
                  state_in  = FSM_IDLE;
               end else begin
                  state_in  = FSM_RETURN;
               end
            end
         end
         FSM_RETURN: begin
            cmd.op    = CELL_ROT_R;
            remain_in = remain_ff - IDX_W'(1);
            if (remain_ff == IDX_W'(1)) begin
               strobe_in = 1'b1;
               state_in  = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // result and rotation registers
   always_ff @(posedge clock) begin
      tail_ff    <= tail_in;
      rd_ff      <= rd_in;
      status_ff  <= status_in;
      remain_ff  <= remain_in;
      back_ff    <= back_in;
      to_read_ff <= to_read_in;
   end

   // drive the result transfer
   assign busy                = (state_ff != FSM_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_data.read_value = VALUE_W'(rd_ff);
   assign rsp_data.head_value = is_empty ? '0 : VALUE_W'(head_data);
   assign rsp_data.tail_value = is_empty ? '0 : VALUE_W'(tail_ff);
   assign rsp_data.count      = COUNT_W'(count_ff);
   assign rsp_data.status     = status_ff;

   `BDQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `BDQ_ASSERT_NEXT(a_accept_answered, clock, reset, start && !busy, strobe_ff || (state_ff != FSM_IDLE), "request neither answered nor in progress")
   `BDQ_ASSERT_SAME(a_strobe_idle, clock, reset, strobe_ff, state_ff == FSM_IDLE, "result shown while ring rotates")
   `BDQ_ASSERT_SAME(a_full_flag, clock, reset, strobe_ff && (status_ff == ST_FULL), count_ff == CNT_W'(DEPTH), "full status with room left")

endmodule
